// File: design/ihls_pkg.sv
// ----------------------------------------------------------------------------
// ihls_pkg
// Shared types, widths and the arctangent table of the RGB to IHLS pipeline.
// ----------------------------------------------------------------------------
package ihls_pkg;

  localparam int unsigned ChanW    = 8;
  localparam int unsigned XyW      = 29;
  localparam int unsigned AngW     = 34;
  localparam int unsigned SumW     = 18;
  localparam int unsigned NumCells = 24;
  localparam int unsigned IdxW     = 5;

  localparam logic [16:0] Sqrt3Q16   = 17'd113512;
  localparam logic [18:0] LumRecip   = 19'd268436;
  localparam int unsigned LumShift   = 28;
  localparam logic signed [AngW-1:0] QuarterTurn = AngW'(64'sh40000000);
  localparam logic signed [AngW-1:0] HalfTurn    = AngW'(64'sh80000000);

  localparam logic [ChanW-1:0] HueThird    = 8'd85;
  localparam logic [ChanW-1:0] HueHalf     = 8'd127;
  localparam logic [ChanW-1:0] HueTwoThird = 8'd170;

  typedef struct packed {
    logic signed [XyW-1:0]  x;
    logic signed [XyW-1:0]  y;
    logic signed [AngW-1:0] ang;
    logic                   special;
    logic [ChanW-1:0]       spec_hue;
    logic                   neg_turn;
    logic [ChanW-1:0]       sat;
    logic [SumW-1:0]        lum_sum;
  } pipe_t;

  function automatic logic signed [AngW-1:0] atan_turn(input logic [IdxW-1:0] idx);
    logic signed [AngW-1:0] t;
    case (idx)
      5'd0:    t = AngW'(64'd536870912);
      5'd1:    t = AngW'(64'd316933406);
      5'd2:    t = AngW'(64'd167458907);
      5'd3:    t = AngW'(64'd85004756);
      5'd4:    t = AngW'(64'd42667331);
      5'd5:    t = AngW'(64'd21354465);
      5'd6:    t = AngW'(64'd10679838);
      5'd7:    t = AngW'(64'd5340245);
      5'd8:    t = AngW'(64'd2670163);
      5'd9:    t = AngW'(64'd1335087);
      5'd10:   t = AngW'(64'd667544);
      5'd11:   t = AngW'(64'd333772);
      5'd12:   t = AngW'(64'd166886);
      5'd13:   t = AngW'(64'd83443);
      5'd14:   t = AngW'(64'd41722);
      5'd15:   t = AngW'(64'd20861);
      5'd16:   t = AngW'(64'd10430);
      5'd17:   t = AngW'(64'd5215);
      5'd18:   t = AngW'(64'd2608);
      5'd19:   t = AngW'(64'd1304);
      5'd20:   t = AngW'(64'd652);
      5'd21:   t = AngW'(64'd326);
      5'd22:   t = AngW'(64'd163);
      5'd23:   t = AngW'(64'd81);
      default: t = '0;
    endcase
    return t;
  endfunction

endpackage

// File: design/ihls_prep.sv
// ----------------------------------------------------------------------------
// ihls_prep
// Entry stage: saturation, luminance sum, special hues and the start vector.
// ----------------------------------------------------------------------------
module ihls_prep (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  logic [7:0]           red_i,
  input  logic [7:0]           green_i,
  input  logic [7:0]           blue_i,
  output logic                 valid_o,
  output ihls_pkg::pipe_t      pipe_o
);
  import ihls_pkg::*;

  logic                   valid_q;
  pipe_t                  pipe_d, pipe_q;
  logic [ChanW-1:0]       mx, mn, absd;
  logic signed [10:0]     diff;
  logic signed [XyW-1:0]  xw;
  logic [24:0]            ym;

  always_comb begin
    mx = red_i;
    mn = red_i;
    if (green_i > mx) mx = green_i;
    if (blue_i > mx) mx = blue_i;
    if (green_i < mn) mn = green_i;
    if (blue_i < mn) mn = blue_i;
    diff = $signed({2'b00, red_i, 1'b0}) - $signed({3'b000, green_i})
           - $signed({3'b000, blue_i});
    xw = {{(XyW-27){diff[10]}}, diff, 16'h0000};
    absd = (green_i > blue_i) ? (green_i - blue_i) : (blue_i - green_i);
    ym = 25'(absd) * 25'(Sqrt3Q16);

    pipe_d.sat      = mx - mn;
    pipe_d.lum_sum  = SumW'(red_i) * SumW'(210) + SumW'(green_i) * SumW'(715)
                      + SumW'(blue_i) * SumW'(72);
    pipe_d.neg_turn = blue_i > green_i;
    pipe_d.special  = 1'b1;
    pipe_d.spec_hue = '0;
    if (red_i == green_i && green_i == blue_i) begin
      pipe_d.spec_hue = '0;
    end else if (green_i == blue_i) begin
      pipe_d.spec_hue = (red_i > green_i) ? '0 : HueHalf;
    end else if (red_i == blue_i && green_i > blue_i) begin
      pipe_d.spec_hue = HueThird;
    end else if (red_i == green_i && blue_i > green_i) begin
      pipe_d.spec_hue = HueTwoThird;
    end else begin
      pipe_d.special = 1'b0;
    end
    if (diff < 0) begin
      pipe_d.x   = $signed({4'b0000, ym});
      pipe_d.y   = -xw;
      pipe_d.ang = QuarterTurn;
    end else begin
      pipe_d.x   = xw;
      pipe_d.y   = $signed({4'b0000, ym});
      pipe_d.ang = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pipe_q <= pipe_d;
    end
  end

  assign valid_o = valid_q;
  assign pipe_o  = pipe_q;

endmodule

// File: design/ihls_cordic_cell.sv
// ----------------------------------------------------------------------------
// ihls_cordic_cell
// One vectoring CORDIC iteration with its own pipeline register.
// ----------------------------------------------------------------------------
module ihls_cordic_cell (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic [ihls_pkg::IdxW-1:0]   stage_idx_i,
  input  logic                        valid_i,
  input  ihls_pkg::pipe_t             pipe_i,
  output logic                        valid_o,
  output ihls_pkg::pipe_t             pipe_o
);
  import ihls_pkg::*;

  logic                   valid_q;
  pipe_t                  pipe_d, pipe_q;
  logic signed [XyW-1:0]  dx, dy;
  logic signed [AngW-1:0] step;

  always_comb begin
    dx     = pipe_i.y >>> stage_idx_i;
    dy     = pipe_i.x >>> stage_idx_i;
    step   = atan_turn(stage_idx_i);
    pipe_d = pipe_i;
    if (!pipe_i.y[XyW-1]) begin
      pipe_d.x   = pipe_i.x + dx;
      pipe_d.y   = pipe_i.y - dy;
      pipe_d.ang = pipe_i.ang + step;
    end else begin
      pipe_d.x   = pipe_i.x - dx;
      pipe_d.y   = pipe_i.y + dy;
      pipe_d.ang = pipe_i.ang - step;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pipe_q <= pipe_d;
    end
  end

  assign valid_o = valid_q;
  assign pipe_o  = pipe_q;

endmodule

// File: design/rgb_to_ihls_pixel_unit.sv
// ----------------------------------------------------------------------------
// rgb_to_ihls_pixel_unit
// RGB pixel to IHLS conversion: entry stage, a row of 24 CORDIC cells and an
// output register that scales the hue and divides the luminance sum.
//
//   channel  signals                                 direction
//   in       in_valid_i in_ready_o red/green/blue_i  sink
//   out      out_valid_o out_ready_i sat/lum/hue_o   source
//
// One pixel is accepted every cycle while no waiting result is held back.
// A pixel passes through the entry stage, one cell per CORDIC iteration and
// the output register, each of them registered.
// The whole pipeline holds while a result waits and is not taken.
// Reset clears the valid bits of all stages.
// ----------------------------------------------------------------------------
module rgb_to_ihls_pixel_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] red_i,
  input  logic [7:0] green_i,
  input  logic [7:0] blue_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] saturation_o,
  output logic [7:0] luminance_o,
  output logic [7:0] hue_o
);
  import ihls_pkg::*;

  logic                   en;
  logic                   chain_v [NumCells+1];
  pipe_t                  chain_p [NumCells+1];
  logic                   out_valid_q;
  logic [ChanW-1:0]       sat_q, lum_q, hue_q;
  logic [ChanW-1:0]       sat_d, lum_d, hue_d;
  logic signed [AngW-1:0] ang_c;
  logic [31:0]            ang_u;
  logic [39:0]            hue_prod;
  logic [36:0]            lum_prod;
  pipe_t                  last;

  assign en = !out_valid_q || out_ready_i;

  ihls_prep u_prep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .red_i   (red_i),
    .green_i (green_i),
    .blue_i  (blue_i),
    .valid_o (chain_v[0]),
    .pipe_o  (chain_p[0])
  );

  for (genvar k = 0; k < NumCells; k++) begin : g_cell
    ihls_cordic_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .en_i        (en),
      .stage_idx_i (IdxW'(k)),
      .valid_i     (chain_v[k]),
      .pipe_i      (chain_p[k]),
      .valid_o     (chain_v[k+1]),
      .pipe_o      (chain_p[k+1])
    );
  end

  always_comb begin
    last  = chain_p[NumCells];
    ang_c = last.ang;
    if (ang_c < 0) ang_c = '0;
    if (ang_c > HalfTurn) ang_c = HalfTurn;
    ang_u = last.neg_turn ? (32'd0 - ang_c[31:0]) : ang_c[31:0];
    hue_prod = {ang_u, 8'h00} - {8'h00, ang_u};
    hue_d = last.special ? last.spec_hue : hue_prod[39:32];
    lum_prod = 37'(last.lum_sum) * 37'(LumRecip);
    lum_d = lum_prod[LumShift+ChanW-1:LumShift];
    sat_d = last.sat;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= chain_v[NumCells];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sat_q <= sat_d;
      lum_q <= lum_d;
      hue_q <= hue_d;
    end
  end

  assign in_ready_o   = en;
  assign out_valid_o  = out_valid_q;
  assign saturation_o = sat_q;
  assign luminance_o  = lum_q;
  assign hue_o        = hue_q;

`ifndef SYNTHESIS
  a_ready_rule: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o == (!out_valid_q || out_ready_i))
    else $error("Input ready does not follow the output stall.");

  a_grey_hue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && saturation_o == 8'd0 |-> hue_o == 8'd0)
    else $error("Grey pixel produced a nonzero hue.");

  a_hold_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(hue_o))
    else $error("Stalled result was lost or changed.");
`endif

endmodule
